[hdl/fpatan_pkg.sv]
// Package for the fixed-point atan2 block: angle constants, the octant tangent
// table and the small types used by the sequencer and its units.
// No dependencies.
package fpatan_pkg;

  localparam int unsigned MagWidth   = 32;  // magnitude of a 32-bit difference
  localparam int unsigned RatioWidth = 15;  // 1.14 ratio, 0 .. 0x4000
  localparam int unsigned FracBits   = 14;
  localparam int unsigned IdxWidth   = 8;   // table index, 0 .. 128
  localparam int unsigned AngleWidth = 11;

  localparam logic [IdxWidth-1:0]   TableLast   = 8'd128;
  localparam logic [IdxWidth:0]     TableLastS  = 9'sd128;
  localparam logic signed [AngleWidth-1:0] HalfTurn    = 11'sd512;
  localparam logic signed [AngleWidth-1:0] QuarterTurn = 11'sd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SEARCH
  } seq_state_e;

  // Octant selection captured when an item is accepted.
  typedef struct packed {
    logic y_major;
    logic x_neg;
    logic y_neg;
  } octant_t;

  // Handshake between the sequencer and a unit.
  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  // Tangent of k/1024 turn in 1.14 fixed point, one entry per step over an octant.
  function automatic logic [RatioWidth-1:0] tan_lut(input logic [IdxWidth-1:0] idx);
    logic [RatioWidth-1:0] t;
    unique case (idx)
      8'd0:   t = 15'h0000; 8'd1:   t = 15'h0064; 8'd2:   t = 15'h00c9; 8'd3:   t = 15'h012d;
      8'd4:   t = 15'h0192; 8'd5:   t = 15'h01f6; 8'd6:   t = 15'h025b; 8'd7:   t = 15'h02c0;
      8'd8:   t = 15'h0324; 8'd9:   t = 15'h0389; 8'd10:  t = 15'h03ee; 8'd11:  t = 15'h0453;
      8'd12:  t = 15'h04b8; 8'd13:  t = 15'h051d; 8'd14:  t = 15'h0582; 8'd15:  t = 15'h05e8;
      8'd16:  t = 15'h064d; 8'd17:  t = 15'h06b3; 8'd18:  t = 15'h0718; 8'd19:  t = 15'h077e;
      8'd20:  t = 15'h07e4; 8'd21:  t = 15'h084a; 8'd22:  t = 15'h08b1; 8'd23:  t = 15'h0917;
      8'd24:  t = 15'h097e; 8'd25:  t = 15'h09e5; 8'd26:  t = 15'h0a4c; 8'd27:  t = 15'h0ab3;
      8'd28:  t = 15'h0b1a; 8'd29:  t = 15'h0b82; 8'd30:  t = 15'h0bea; 8'd31:  t = 15'h0c52;
      8'd32:  t = 15'h0cba; 8'd33:  t = 15'h0d23; 8'd34:  t = 15'h0d8c; 8'd35:  t = 15'h0df5;
      8'd36:  t = 15'h0e5f; 8'd37:  t = 15'h0ec8; 8'd38:  t = 15'h0f32; 8'd39:  t = 15'h0f9d;
      8'd40:  t = 15'h1007; 8'd41:  t = 15'h1072; 8'd42:  t = 15'h10de; 8'd43:  t = 15'h114a;
      8'd44:  t = 15'h11b6; 8'd45:  t = 15'h1222; 8'd46:  t = 15'h128f; 8'd47:  t = 15'h12fc;
      8'd48:  t = 15'h136a; 8'd49:  t = 15'h13d8; 8'd50:  t = 15'h1446; 8'd51:  t = 15'h14b5;
      8'd52:  t = 15'h1524; 8'd53:  t = 15'h1594; 8'd54:  t = 15'h1604; 8'd55:  t = 15'h1675;
      8'd56:  t = 15'h16e6; 8'd57:  t = 15'h1757; 8'd58:  t = 15'h17ca; 8'd59:  t = 15'h183c;
      8'd60:  t = 15'h18b0; 8'd61:  t = 15'h1923; 8'd62:  t = 15'h1998; 8'd63:  t = 15'h1a0c;
      8'd64:  t = 15'h1a82; 8'd65:  t = 15'h1af8; 8'd66:  t = 15'h1b6f; 8'd67:  t = 15'h1be6;
      8'd68:  t = 15'h1c5e; 8'd69:  t = 15'h1cd7; 8'd70:  t = 15'h1d50; 8'd71:  t = 15'h1dca;
      8'd72:  t = 15'h1e45; 8'd73:  t = 15'h1ec0; 8'd74:  t = 15'h1f3c; 8'd75:  t = 15'h1fb9;
      8'd76:  t = 15'h2037; 8'd77:  t = 15'h20b5; 8'd78:  t = 15'h2134; 8'd79:  t = 15'h21b4;
      8'd80:  t = 15'h2235; 8'd81:  t = 15'h22b7; 8'd82:  t = 15'h2339; 8'd83:  t = 15'h23bd;
      8'd84:  t = 15'h2441; 8'd85:  t = 15'h24c6; 8'd86:  t = 15'h254c; 8'd87:  t = 15'h25d4;
      8'd88:  t = 15'h265c; 8'd89:  t = 15'h26e5; 8'd90:  t = 15'h276f; 8'd91:  t = 15'h27fa;
      8'd92:  t = 15'h2887; 8'd93:  t = 15'h2914; 8'd94:  t = 15'h29a2; 8'd95:  t = 15'h2a32;
      8'd96:  t = 15'h2ac3; 8'd97:  t = 15'h2b55; 8'd98:  t = 15'h2be8; 8'd99:  t = 15'h2c7d;
      8'd100: t = 15'h2d12; 8'd101: t = 15'h2da9; 8'd102: t = 15'h2e42; 8'd103: t = 15'h2edc;
      8'd104: t = 15'h2f77; 8'd105: t = 15'h3013; 8'd106: t = 15'h30b1; 8'd107: t = 15'h3151;
      8'd108: t = 15'h31f2; 8'd109: t = 15'h3294; 8'd110: t = 15'h3338; 8'd111: t = 15'h33de;
      8'd112: t = 15'h3486; 8'd113: t = 15'h352f; 8'd114: t = 15'h35d9; 8'd115: t = 15'h3686;
      8'd116: t = 15'h3734; 8'd117: t = 15'h37e5; 8'd118: t = 15'h3897; 8'd119: t = 15'h394b;
      8'd120: t = 15'h3a01; 8'd121: t = 15'h3ab9; 8'd122: t = 15'h3b73; 8'd123: t = 15'h3c30;
      8'd124: t = 15'h3cee; 8'd125: t = 15'h3daf; 8'd126: t = 15'h3e72; 8'd127: t = 15'h3f38;
      default: t = 15'h4000;
    endcase
    return t;
  endfunction

endpackage

[hdl/fpatan_div.sv]
// Bit-serial restoring divider: floor(small * 2^14 / big) for small <= big.
// Depends on fpatan_pkg.
module fpatan_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpatan_pkg::unit_ctrl_t               ctrl_i,
  input  logic [fpatan_pkg::MagWidth-1:0]      small_i,
  input  logic [fpatan_pkg::MagWidth-1:0]      big_i,
  output logic                                 done_o,
  output logic [fpatan_pkg::RatioWidth-1:0]    quot_o
);

  localparam int unsigned RemWidth = fpatan_pkg::MagWidth + 1;
  localparam logic [3:0]  LastStep = 4'(fpatan_pkg::FracBits);

  logic                                active_q, active_d;
  logic [3:0]                          cnt_q, cnt_d;
  logic [RemWidth-1:0]                 rem_q, rem_d;
  logic [fpatan_pkg::RatioWidth-1:0]   quot_q, quot_d;
  logic                                done_q, done_d;
  logic [RemWidth-1:0]                 shifted;
  logic [RemWidth:0]                   diff;

  // The first step compares the unshifted remainder; later steps shift in a zero.
  assign shifted = (cnt_q == 4'd0) ? rem_q : {rem_q[RemWidth-2:0], 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, big_i};

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    done_d   = 1'b0;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      cnt_d    = 4'd0;
      rem_d    = {1'b0, small_i};
    end else if (active_q) begin
      rem_d  = diff[RemWidth] ? shifted : diff[RemWidth-1:0];
      quot_d = {quot_q[fpatan_pkg::RatioWidth-2:0], ~diff[RemWidth]};
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == LastStep) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= 4'd0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/fpatan_search.sv]
// Binary search of the tangent table, one probe per cycle; returns the exact
// match or the last probed midpoint. Depends on fpatan_pkg.
module fpatan_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpatan_pkg::unit_ctrl_t               ctrl_i,
  input  logic [fpatan_pkg::RatioWidth-1:0]    ratio_i,
  output logic                                 done_o,
  output logic [fpatan_pkg::IdxWidth-1:0]      index_o
);

  localparam int unsigned BW = fpatan_pkg::IdxWidth + 1;

  logic                               active_q, active_d;
  logic signed [BW-1:0]               lo_q, lo_d, hi_q, hi_d;
  logic [fpatan_pkg::IdxWidth-1:0]    mid_q, mid_d;
  logic                               done_q, done_d;
  logic [BW-1:0]                      sum;
  logic [fpatan_pkg::IdxWidth-1:0]    mid;
  logic [fpatan_pkg::RatioWidth-1:0]  probe;

  // Inside the loop lo and hi are both non-negative, so the sum fits unsigned.
  assign sum   = BW'(lo_q + hi_q);
  assign mid   = sum[BW-1:1];
  assign probe = fpatan_pkg::tan_lut(mid);

  always_comb begin
    active_d = active_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    done_d   = 1'b0;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      lo_d     = '0;
      hi_d     = fpatan_pkg::TableLastS;
    end else if (active_q) begin
      if (lo_q > hi_q) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        mid_d = mid;
        if (probe > ratio_i) begin
          hi_d = $signed({1'b0, mid}) - BW'(1);
        end else if (probe < ratio_i) begin
          lo_d = $signed({1'b0, mid}) + BW'(1);
        end else begin
          active_d = 1'b0;
          done_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
  end

  assign done_o  = done_q;
  assign index_o = mid_q;

endmodule

[hdl/fixed_point_atan2_lookup.sv]
// Fixed-point atan2: angle in 1024ths of a turn from two signed differences.
// A zero pair is answered in the cycle after it is accepted. Any other item passes from the
// accepting edge through a load state, the bit-serial divider steps, a hand-off to the search,
// the table probes plus a closing step when no probe hits, and the output register to the done strobe.
// A zero pair never raises busy; for any other item busy stays high until it drops with the strobe.
// Reset (rst_ni, asynchronous, active low) idles the sequencer and clears the strobe.
module fixed_point_atan2_lookup (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [31:0]                      delta_x_i,
  input  logic signed [31:0]                      delta_y_i,
  output logic                                    done_o,
  output logic signed [fpatan_pkg::AngleWidth-1:0] angle_o
);

  // Magnitudes of the inputs. Negating modulo 2^32 gives -2^31 the magnitude
  // 2^31 exactly, which is what an unsigned 32-bit register holds.
  logic [fpatan_pkg::MagWidth-1:0] mag_x, mag_y;
  logic                            x_not_pos, y_not_pos, y_major_in, both_zero, accept;

  assign mag_x      = delta_x_i[31] ? (~delta_x_i + 32'd1) : delta_x_i;
  assign mag_y      = delta_y_i[31] ? (~delta_y_i + 32'd1) : delta_y_i;
  // Zero counts as negative when the octant is chosen.
  assign x_not_pos  = delta_x_i[31] | (delta_x_i == '0);
  assign y_not_pos  = delta_y_i[31] | (delta_y_i == '0);
  assign y_major_in = mag_y > mag_x;
  assign both_zero  = (delta_x_i == '0) && (delta_y_i == '0);
  assign accept     = start && !busy;

  fpatan_pkg::seq_state_e          state_q, state_d;
  fpatan_pkg::octant_t             oct_q;
  logic [fpatan_pkg::MagWidth-1:0] small_q, big_q;
  logic                            done_q, done_d;
  logic signed [fpatan_pkg::AngleWidth-1:0] angle_q, angle_d;

  fpatan_pkg::unit_ctrl_t             div_ctrl, srch_ctrl;
  logic                               div_done, srch_done;
  logic [fpatan_pkg::RatioWidth-1:0]  ratio;
  logic [fpatan_pkg::IdxWidth-1:0]    index;
  logic signed [fpatan_pkg::AngleWidth-1:0] a;

  // The divider runs on the registered operands; its done pulse launches the search.
  assign div_ctrl.start  = (state_q == fpatan_pkg::ST_LOAD);
  assign srch_ctrl.start = div_done;

  fpatan_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .small_i (small_q),
    .big_i   (big_q),
    .done_o  (div_done),
    .quot_o  (ratio)
  );

  fpatan_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (srch_ctrl),
    .ratio_i (ratio),
    .done_o  (srch_done),
    .index_o (index)
  );

  assign a = $signed({{(fpatan_pkg::AngleWidth-fpatan_pkg::IdxWidth){1'b0}}, index});

  // Sequencer and octant mapping. When the vertical magnitude dominates, the
  // table angle is measured from the vertical axis; otherwise from the horizontal.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    angle_d = angle_q;
    unique case (state_q)
      fpatan_pkg::ST_IDLE: begin
        if (accept) begin
          if (both_zero) begin
            angle_d = '0;
            done_d  = 1'b1;
          end else begin
            state_d = fpatan_pkg::ST_LOAD;
          end
        end
      end
      fpatan_pkg::ST_LOAD: begin
        state_d = fpatan_pkg::ST_DIV;
      end
      fpatan_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = fpatan_pkg::ST_SEARCH;
        end
      end
      fpatan_pkg::ST_SEARCH: begin
        if (srch_done) begin
          state_d = fpatan_pkg::ST_IDLE;
          done_d  = 1'b1;
          if (oct_q.y_major) begin
            priority if (oct_q.y_neg && oct_q.x_neg) begin
              angle_d = a - fpatan_pkg::HalfTurn;
            end else if (oct_q.y_neg) begin
              angle_d = fpatan_pkg::HalfTurn - a;
            end else if (oct_q.x_neg) begin
              angle_d = -a;
            end else begin
              angle_d = a;
            end
          end else begin
            priority if (oct_q.y_neg && oct_q.x_neg) begin
              angle_d = -fpatan_pkg::QuarterTurn - a;
            end else if (oct_q.y_neg) begin
              angle_d = fpatan_pkg::QuarterTurn + a;
            end else if (oct_q.x_neg) begin
              angle_d = a - fpatan_pkg::QuarterTurn;
            end else begin
              angle_d = fpatan_pkg::QuarterTurn - a;
            end
          end
        end
      end
      default: begin
        state_d = fpatan_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpatan_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Operands and octant flags are captured once per accepted item.
  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    if (accept) begin
      oct_q.y_major <= y_major_in;
      oct_q.x_neg   <= x_not_pos;
      oct_q.y_neg   <= y_not_pos;
      big_q         <= y_major_in ? mag_y : mag_x;
      small_q       <= y_major_in ? mag_x : mag_y;
    end
  end

  assign busy    = (state_q != fpatan_pkg::ST_IDLE);
  assign done_o  = done_q;
  assign angle_o = angle_q;

  // The strobe only appears once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // Two zero differences give a zero angle on the next cycle.
  a_zero_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && delta_x_i == '0 && delta_y_i == '0) |=> (done_o && angle_o == '0))
    else $error("zero item not answered at once");

  // Any other accepted item keeps the block busy.
  a_nonzero_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !(delta_x_i == '0 && delta_y_i == '0)) |=> (busy && !done_o))
    else $error("item accepted without going busy");

  // The angle always lands within half a turn either way.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_o >= -fpatan_pkg::HalfTurn && angle_o <= fpatan_pkg::HalfTurn))
    else $error("angle out of range");

endmodule
